@@ hdl/nig_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nig_pkg;

  // Sizes of the index space and of the candidate words.
  localparam int MaxPolyLen   = 2048;
  localparam int MaxIndexBits = 16;
  localparam int MinIndexBits = 9;
  localparam int NumPolys     = 3;
  localparam int IdxW         = $clog2(MaxPolyLen);
  localparam int PolyW        = 2;
  localparam int PolyCntW     = PolyW + 1;

  // Configuration register widths.
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int CBitsW       = 5;
  localparam int LimitW       = 16;
  localparam int LenW         = 12;
  localparam int CountW       = 12;
  localparam int SmallCountW  = 8;

  // Bit packer widths.
  localparam int OctetW       = 8;
  localparam int CandW        = MaxIndexBits;
  localparam int NeedW        = 5;
  localparam int LoCntW       = 3;
  localparam int LoBitsW      = 7;

  // Used-mark store: rows of marks, cleared one row per cycle.
  localparam int MarkRowW     = 32;
  localparam int BitSelW      = $clog2(MarkRowW);
  localparam int MarkRows     = MaxPolyLen / MarkRowW;
  localparam int RowAddrW     = $clog2(MarkRows);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRODUCT_FORM = 3'd0,
    CFG_C_BITS       = 3'd1,
    CFG_LIMIT        = 3'd2,
    CFG_POLY_LEN     = 3'd3,
    CFG_COUNT_FIRST  = 3'd4,
    CFG_COUNT_SECOND = 3'd5,
    CFG_COUNT_THIRD  = 3'd6
  } nig_cfg_e;

  // Input item.
  typedef struct packed {
    logic [OctetW-1:0] octet;
    logic              start_req;
  } nig_in_t;

  // Result item.
  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [PolyW-1:0] poly_number;
    logic             last_in_poly;
    logic             last;
  } nig_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic pack_reset;
    logic enter;
    logic enter_next;
    logic pack;
    logic div_start;
    logic mark_rd;
    logic emit;
    logic clr_start;
    logic clr_step;
  } nig_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;
    logic done;
    logic enter_found;
    logic cand_ready;
    logic cand_ok;
    logic div_busy;
    logic mark_hit;
    logic out_free;
    logic lip;
    logic clr_last;
  } nig_stat_t;

endpackage

`default_nettype wire

@@ hdl/nig_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nig_div import nig_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CandW-1:0]  dividend_i,
  input  wire logic [LenW-1:0]   divisor_i,
  output logic                   busy_o,
  output logic [IdxW-1:0]        remainder_o
);

  localparam int StepW = $clog2(CandW + 1);

  logic [StepW-1:0] step_q, step_d;
  logic [CandW-1:0] num_q, num_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW:0]    trial;

  // One restoring step per cycle, dividend bits taken from the top.
  always_comb begin
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[CandW-1]};
    if (start_i) begin
      step_d = StepW'(CandW);
      num_d  = dividend_i;
      rem_d  = '0;
    end else if (step_q != '0) begin
      step_d = step_q - StepW'(1);
      num_d  = {num_q[CandW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = LenW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign busy_o      = (step_q != '0);
  assign remainder_o = rem_q[IdxW-1:0];

endmodule

`default_nettype wire

@@ hdl/nig_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nig_dp import nig_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire nig_in_t             in_data_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output nig_out_t                 out_data_o,
  input  wire nig_cmd_t            cmd_i,
  output nig_stat_t                stat_o
);

  // Configuration registers.
  logic                   product_form_q;
  logic [CBitsW-1:0]      c_bits_q;
  logic [LimitW-1:0]      limit_q;
  logic [LenW-1:0]        poly_len_q;
  logic [CountW-1:0]      count_first_q;
  logic [SmallCountW-1:0] count_second_q;
  logic [SmallCountW-1:0] count_third_q;

  // Latched item.
  logic [OctetW-1:0] octet_q;
  logic              start_q;

  // Bit packer state.
  logic [CandW-1:0]   part_q, part_d, part_w;
  logic [NeedW-1:0]   need_q, need_d, need_w;
  logic [LoCntW-1:0]  lo_cnt_q, lo_cnt_d;
  logic [LoBitsW-1:0] lo_bits_q, lo_bits_d;
  logic [CandW+OctetW-1:0] shifted;
  logic [CandW-1:0]   cand;
  logic               cand_ready;

  // Generation state.
  logic [PolyW-1:0]  cur_q;
  logic [CountW-1:0] remaining_q, rem_dec;
  logic              done_q;
  logic              lip;

  // Effective settings and polynomial entry search.
  logic [LenW-1:0]     eff_len;
  logic [NeedW-1:0]    eff_bits;
  logic [CountW-1:0]   cnt_sat [NumPolys];
  logic [CountW-1:0]   cnt_raw [NumPolys];
  logic [PolyCntW-1:0] enter_from;
  logic [PolyCntW-1:0] poly_total;
  logic                enter_found;
  logic [PolyW-1:0]    enter_sel;

  // Divider and used-mark store.
  logic                div_busy;
  logic [IdxW-1:0]     div_rem;
  logic [MarkRowW-1:0] mark_mem [MarkRows];
  logic [MarkRowW-1:0] mark_row_q;
  logic [IdxW-1:0]     idx_q;
  logic [RowAddrW-1:0] clr_cnt_q;

  // Result register.
  logic     out_valid_q;
  nig_out_t out_data_q;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_form_q <= 1'b0;
      c_bits_q       <= CBitsW'(11);
      limit_q        <= LimitW'(2048);
      poly_len_q     <= LenW'(1024);
      count_first_q  <= '0;
      count_second_q <= '0;
      count_third_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRODUCT_FORM: product_form_q <= cfg_data_i[0];
        CFG_C_BITS:       c_bits_q       <= cfg_data_i[CBitsW-1:0];
        CFG_LIMIT:        limit_q        <= cfg_data_i[LimitW-1:0];
        CFG_POLY_LEN:     poly_len_q     <= cfg_data_i[LenW-1:0];
        CFG_COUNT_FIRST:  count_first_q  <= cfg_data_i[CountW-1:0];
        CFG_COUNT_SECOND: count_second_q <= cfg_data_i[SmallCountW-1:0];
        CFG_COUNT_THIRD:  count_third_q  <= cfg_data_i[SmallCountW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length and candidate width to their supported ranges.
  always_comb begin
    if (poly_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (poly_len_q > LenW'(MaxPolyLen)) begin
      eff_len = LenW'(MaxPolyLen);
    end else begin
      eff_len = poly_len_q;
    end
    if (c_bits_q < CBitsW'(MinIndexBits)) begin
      eff_bits = NeedW'(MinIndexBits);
    end else if (c_bits_q > CBitsW'(MaxIndexBits)) begin
      eff_bits = NeedW'(MaxIndexBits);
    end else begin
      eff_bits = NeedW'(c_bits_q);
    end
  end

  // Saturated counts and the first non-empty polynomial from the start point.
  always_comb begin
    cnt_raw[0] = product_form_q ? CountW'(count_first_q[SmallCountW-1:0])
                                : count_first_q;
    cnt_raw[1] = CountW'(count_second_q);
    cnt_raw[2] = CountW'(count_third_q);
    enter_from = cmd_i.enter_next ? (PolyCntW'(cur_q) + PolyCntW'(1)) : '0;
    poly_total = product_form_q ? PolyCntW'(NumPolys) : PolyCntW'(1);
    enter_found = 1'b0;
    enter_sel   = '0;
    for (int p = NumPolys - 1; p >= 0; p--) begin
      cnt_sat[p] = (cnt_raw[p] > CountW'(eff_len)) ? CountW'(eff_len) : cnt_raw[p];
      if (PolyCntW'(p) >= enter_from && PolyCntW'(p) < poly_total &&
          cnt_sat[p] != '0) begin
        enter_found = 1'b1;
        enter_sel   = PolyW'(p);
      end
    end
  end

  // Bit packer: leftovers first, then octet bits MSB first.
  always_comb begin
    part_w    = part_q;
    need_w    = need_q;
    lo_cnt_d  = lo_cnt_q;
    lo_bits_d = lo_bits_q;
    if (need_q == '0) begin
      part_w    = CandW'(lo_bits_q);
      need_w    = eff_bits - NeedW'(lo_cnt_q);
      lo_cnt_d  = '0;
      lo_bits_d = '0;
    end
    cand_ready = (need_w <= NeedW'(OctetW));
    shifted    = {part_w, octet_q} >> (NeedW'(OctetW) - need_w);
    cand       = shifted[CandW-1:0];
    if (cand_ready) begin
      part_d    = '0;
      need_d    = '0;
      lo_cnt_d  = LoCntW'(NeedW'(OctetW) - need_w);
      lo_bits_d = LoBitsW'(octet_q & (8'hff >> need_w));
    end else begin
      part_d    = {part_w[CandW-OctetW-1:0], octet_q};
      need_d    = need_w - NeedW'(OctetW);
    end
  end

  // Count of the current polynomial after this index.
  assign rem_dec = (remaining_q != '0) ? (remaining_q - CountW'(1)) : '0;
  assign lip     = (rem_dec == '0);

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      octet_q <= in_data_i.octet;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else if (cmd_i.latch) begin
      start_q <= in_data_i.start_req;
    end else if (cmd_i.pack_reset) begin
      start_q <= 1'b0;
    end
  end

  // Packer and generation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= '0;
      need_q      <= '0;
      lo_cnt_q    <= '0;
      lo_bits_q   <= '0;
      cur_q       <= '0;
      remaining_q <= '0;
      done_q      <= 1'b1;
    end else begin
      if (cmd_i.pack_reset) begin
        part_q      <= '0;
        need_q      <= '0;
        lo_cnt_q    <= '0;
        lo_bits_q   <= '0;
        cur_q       <= '0;
        remaining_q <= '0;
      end else if (cmd_i.pack) begin
        part_q    <= part_d;
        need_q    <= need_d;
        lo_cnt_q  <= lo_cnt_d;
        lo_bits_q <= lo_bits_d;
      end
      if (cmd_i.emit) begin
        remaining_q <= rem_dec;
      end
      if (cmd_i.enter) begin
        if (enter_found) begin
          cur_q       <= enter_sel;
          remaining_q <= cnt_sat[enter_sel];
          done_q      <= 1'b0;
        end else begin
          done_q      <= 1'b1;
        end
      end
    end
  end

  // Candidate reduction modulo the effective length.
  nig_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (cand),
    .divisor_i   (eff_len),
    .busy_o      (div_busy),
    .remainder_o (div_rem)
  );

  // Used-mark store: row read, set on emit, rows zeroed by the clear sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_rd) begin
      mark_row_q <= mark_mem[div_rem[IdxW-1:BitSelW]];
      idx_q      <= div_rem;
    end
    if (cmd_i.emit) begin
      mark_mem[idx_q[IdxW-1:BitSelW]] <=
        mark_row_q | (MarkRowW'(1) << idx_q[BitSelW-1:0]);
    end else if (cmd_i.clr_step) begin
      mark_mem[clr_cnt_q] <= '0;
    end
  end

  // Clear sweep row counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + RowAddrW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q.index        <= idx_q;
      out_data_q.poly_number  <= cur_q;
      out_data_q.last_in_poly <= lip;
      out_data_q.last         <= lip & ~enter_found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status towards the controller.
  always_comb begin
    stat_o.start       = start_q;
    stat_o.done        = done_q;
    stat_o.enter_found = enter_found;
    stat_o.cand_ready  = cand_ready;
    stat_o.cand_ok     = (cand < limit_q);
    stat_o.div_busy    = div_busy;
    stat_o.mark_hit    = mark_row_q[idx_q[BitSelW-1:0]];
    stat_o.out_free    = ~out_valid_q | out_ready_i;
    stat_o.lip         = lip;
    stat_o.clr_last    = (clr_cnt_q == RowAddrW'(MarkRows - 1));
  end

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // The mark row is only looked up once the remainder has settled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_rd |-> !div_busy)
    else $error("mark read while divider busy");

  // An emitted index is presented in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted item not presented");

  // Packing only happens inside an active generation after any start is handled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pack |-> (!done_q && !start_q))
    else $error("packing outside a generation");

endmodule

`default_nettype wire

@@ hdl/nig_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nig_ctrl import nig_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire nig_stat_t stat_i,
  output nig_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PACK = 5'b00010,
    S_DIV  = 5'b00100,
    S_TEST = 5'b01000,
    S_CLR  = 5'b10000
  } nig_state_e;

  nig_state_e state_q, state_d;
  logic       clr_ret_q, clr_ret_d;

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    clr_ret_d = clr_ret_q;
    cmd_o     = '0;
    cmd_o.enter_next = (state_q == S_TEST);
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_PACK;
        end
      end
      S_PACK: begin
        if (stat_i.start) begin
          // Start of a generation: clear state, open the first polynomial.
          cmd_o.pack_reset = 1'b1;
          cmd_o.enter      = 1'b1;
          if (stat_i.enter_found) begin
            cmd_o.clr_start = 1'b1;
            clr_ret_d       = 1'b1;
            state_d         = S_CLR;
          end else begin
            state_d = S_IDLE;
          end
        end else if (stat_i.done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.pack = 1'b1;
          if (stat_i.cand_ready && stat_i.cand_ok) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.mark_rd = 1'b1;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        if (stat_i.mark_hit) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.lip) begin
            cmd_o.enter = 1'b1;
            if (stat_i.enter_found) begin
              cmd_o.clr_start = 1'b1;
              clr_ret_d       = 1'b0;
              state_d         = S_CLR;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = clr_ret_q ? S_PACK : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      clr_ret_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ret_q <= clr_ret_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ntru_index_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Index generator for sparse ternary polynomials. Mask-generator octets come in
// one item at a time and are packed MSB first into c_bits-wide candidates;
// a candidate below limit is reduced modulo poly_len and delivered as an index
// if not yet used in the current polynomial (one or, in product form, three
// polynomials). An octet that completes an in-range candidate passes through
// the one-bit-per-cycle remainder unit and then the registered read of the
// used-mark store. Opening each polynomial adds a sweep that zeroes the
// used-mark store one 32-bit row per cycle, during which no item is accepted.
// A waiting result holds the block only when the next index is ready to be
// delivered. Configuration writes are taken in any cycle.
module ntru_index_generator import nig_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire nig_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output nig_out_t                 out_data_o
);

  nig_cmd_t  cmd;
  nig_stat_t stat;

  // Register writes always complete at once.
  assign cfg_ready_o = 1'b1;

  nig_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nig_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
